// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: src/vhsg_pkg.sv
package vhsg_pkg;

  localparam int unsigned MemCellsDef    = 4096;
  localparam int unsigned MarginBytesDef = 64;

  localparam int unsigned CfgW = 15;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_HEAP_BASE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STACK_TOP = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MEM_SIZE  = 2'd2;

  localparam logic [CfgW-1:0] HeapBaseRst = 15'd0;
  localparam logic [CfgW-1:0] StackTopRst = 15'd16384;
  localparam logic [CfgW-1:0] MemSizeRst  = 15'd16384;
  localparam logic [31:0]     StackPtrRst = 32'd16384;

  typedef enum logic [2:0] {
    CMD_PUSH    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_POP     = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_CHECK   = 3'd4,
    CMD_RESTART = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_HEAPLOW  = 2'd1,
    STS_STACKLOW = 2'd2,
    STS_INVALID  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// File: src/vhsg_ram.sv
module vhsg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/vm_heap_stack_guard_top.sv
// Heap and stack guard for one region of 4-byte cells, addressed in bytes.
// Command channel: a transaction is taken at a rising edge where start is
// high and busy is low; cmd_i, push_value_i, cell_count_i and
// local_address_i are sampled at that edge.
// Result channel: done_o is high for exactly one cycle, after the execute state
// that follows the accepting edge, and status_o, result_address_o, heap_top_o,
// stack_pointer_o and push_count_o are valid in that cycle. The receiver
// cannot stall, so results are never held back.
// Sequencing: an accepted command runs in the execute state, where busy stays
// high, so a new command is taken only after the block is back in idle. The pop
// header read is launched at the accepting edge, and the compare and pointer
// update follow in the execute cycle, where pushes and allocations also write
// the memory.
// Configuration: cfg_we_i writes register cfg_index_i (0 heap base, 1 stack
// top, 2 memory size) with cfg_wdata_i at once; index 3 is ignored. Writes
// are meant only while the block is idle.
// Reset: the pointers and registers take their reset values, then busy
// stays high while a clearing pass zeroes the memory.
`include "assert_macros.svh"

module vm_heap_stack_guard_top #(
  parameter int unsigned MEM_CELLS    = vhsg_pkg::MemCellsDef,
  parameter int unsigned MARGIN_BYTES = vhsg_pkg::MarginBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   cmd_i,
  input  logic [31:0]                  push_value_i,
  input  logic [12:0]                  cell_count_i,
  input  logic [31:0]                  local_address_i,
  input  logic                         cfg_we_i,
  input  logic [vhsg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [vhsg_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [31:0]                  result_address_o,
  output logic [31:0]                  heap_top_o,
  output logic [14:0]                  stack_pointer_o,
  output logic [12:0]                  push_count_o
);

  import vhsg_pkg::*;

  localparam int unsigned AW = $clog2(MEM_CELLS);
  localparam logic [29:0] CellLimit = 30'(MEM_CELLS);
  localparam logic [AW-1:0] LastCell = AW'(MEM_CELLS - 1);

  // Configuration registers.
  logic [CfgW-1:0] heap_floor_q, stack_top_q, region_size_q;

  // Architectural state.
  state_e      state_q, state_d;
  logic [31:0] heap_ptr_q, heap_ptr_d;
  logic [31:0] stack_ptr_q, stack_ptr_d;
  logic [12:0] pushes_q, pushes_d;
  logic [AW-1:0] clr_cnt_q;

  // Command captured at acceptance.
  cmd_e        cmd_q;
  logic [31:0] value_q;
  logic [12:0] cells_q;
  logic [31:0] laddr_q;
  logic        rd_ok_q;

  // Result registers.
  logic        done_q, done_d;
  logic [1:0]  status_q, status_d;
  logic [31:0] result_q, result_d;

  // Memory port.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic        accept;
  logic [31:0] in_a;

  // Execute-cycle datapath.
  logic [31:0] below, bytes, room, pop_a, hdr, chain;
  logic [33:0] margin_sum, below_ext;
  logic [31:0] base_ext, size_ext;
  logic        stack_low, heap_low, pop_bad_range, release_bad;
  logic        in_gap, check_bad;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // The pop header read is launched at acceptance from the raw address.
  assign in_a      = local_address_i - 32'd4;
  assign ram_re    = accept;
  assign ram_raddr = in_a[AW+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_floor_q  <= HeapBaseRst;
      stack_top_q   <= StackTopRst;
      region_size_q <= MemSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_HEAP_BASE: heap_floor_q  <= cfg_wdata_i;
        CFG_STACK_TOP: stack_top_q   <= cfg_wdata_i;
        CFG_MEM_SIZE:  region_size_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      heap_ptr_q  <= '0;
      stack_ptr_q <= StackPtrRst;
      pushes_q    <= '0;
      clr_cnt_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      heap_ptr_q  <= heap_ptr_d;
      stack_ptr_q <= stack_ptr_d;
      pushes_q    <= pushes_d;
      done_q      <= done_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(cmd_i);
      value_q <= push_value_i;
      cells_q <= cell_count_i;
      laddr_q <= local_address_i;
      rd_ok_q <= (in_a[31:2] < CellLimit);
    end
    if (state_q == ST_EXEC) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  // Compare terms; the margin sum is exact, so it is formed in 34 bits.
  assign below      = stack_ptr_q - 32'd4;
  assign margin_sum = {{2{heap_ptr_q[31]}}, heap_ptr_q} + 34'(MARGIN_BYTES);
  assign below_ext  = {{2{below[31]}}, below};
  assign stack_low  = $signed(margin_sum) > $signed(below_ext);

  assign bytes    = {17'd0, cells_q, 2'b00};
  assign room     = stack_ptr_q - heap_ptr_q - bytes;
  assign heap_low = $signed(room) < $signed(32'(MARGIN_BYTES));

  assign base_ext      = {17'd0, heap_floor_q};
  assign size_ext      = {17'd0, region_size_q};
  assign pop_a         = laddr_q - 32'd4;
  assign pop_bad_range = ($signed(pop_a) < $signed(base_ext)) ||
                         ($signed(pop_a) >= $signed(stack_ptr_q));
  // A header outside the store reads as zero.
  assign hdr   = rd_ok_q ? ram_rdata : 32'd0;
  assign chain = heap_ptr_q - {hdr[29:0], 2'b00} - 32'd4;

  assign release_bad = $signed(laddr_q) < $signed(base_ext);

  assign in_gap    = ($signed(laddr_q) >= $signed(heap_ptr_q)) &&
                     ($signed(laddr_q) < $signed(stack_ptr_q));
  assign check_bad = in_gap || laddr_q[31] || ($signed(laddr_q) >= $signed(size_ext));

  always_comb begin
    state_d     = state_q;
    heap_ptr_d  = heap_ptr_q;
    stack_ptr_d = stack_ptr_q;
    pushes_d    = pushes_q;
    done_d      = 1'b0;
    status_d    = STS_OK;
    result_d    = '0;
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_q;
    ram_wdata   = '0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_q == LastCell) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        unique case (cmd_q)
          CMD_PUSH: begin
            if (stack_low) begin
              status_d = STS_STACKLOW;
            end else begin
              stack_ptr_d = below;
              pushes_d    = pushes_q + 13'd1;
              ram_we      = (below[31:2] < CellLimit);
              ram_waddr   = below[AW+1:2];
              ram_wdata   = value_q;
            end
          end
          CMD_ALLOC: begin
            if (heap_low) begin
              status_d = STS_HEAPLOW;
            end else begin
              ram_we     = (heap_ptr_q[31:2] < CellLimit);
              ram_waddr  = heap_ptr_q[AW+1:2];
              ram_wdata  = {19'd0, cells_q};
              result_d   = heap_ptr_q + 32'd4;
              heap_ptr_d = heap_ptr_q + 32'd4 + bytes;
            end
          end
          CMD_POP: begin
            if (pop_bad_range || (chain != pop_a)) begin
              status_d = STS_INVALID;
            end else begin
              heap_ptr_d = pop_a;
            end
          end
          CMD_RELEASE: begin
            if (release_bad) begin
              status_d = STS_INVALID;
            end else begin
              heap_ptr_d = pop_a;
            end
          end
          CMD_CHECK: begin
            if (check_bad) begin
              status_d = STS_INVALID;
            end else begin
              result_d = laddr_q;
            end
          end
          CMD_RESTART: begin
            heap_ptr_d  = base_ext;
            stack_ptr_d = {17'd0, stack_top_q};
            pushes_d    = '0;
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  vhsg_ram #(
    .Width(32),
    .Depth(MEM_CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign result_address_o = result_q;
  assign heap_top_o       = heap_ptr_q;
  assign stack_pointer_o  = stack_ptr_q[14:0];
  assign push_count_o     = pushes_q;

  // An accepted transaction always goes to the execute cycle next.
  `ASSERT_CLK(a_accept_exec, clk_i, rst_ni, accept |=> (state_q == ST_EXEC))
  // A result strobe follows an execute cycle and nothing else.
  `ASSERT_CLK(a_done_after_exec, clk_i, rst_ni, done_o |-> $past(state_q == ST_EXEC))
  // While a result is shown the block is ready for the next transaction.
  `ASSERT_NEVER(a_done_busy, clk_i, rst_ni, done_o && busy)
  // The memory is never written while a command is waiting for its header read.
  `ASSERT_CLK(a_no_write_on_accept, clk_i, rst_ni, (state_q == ST_IDLE) |-> !ram_we)

endmodule
